>>> sv/slnr_pkg.sv
// constants, types and state codes for the sound lump nearest resampler
// no dependencies; imported by slnr_header and sound_lump_nearest_resampler
package slnr_pkg;

   localparam int unsigned OUT_RATE     = 22050;
   localparam int unsigned MAX_RUN      = 64;
   localparam int unsigned LUMP_VERSION = 3;
   localparam int unsigned HEADER_BYTES = 8;

   localparam int unsigned RATE_W   = 16;
   localparam int unsigned TOTAL_W  = 32;
   localparam int unsigned OUT_W    = $clog2(OUT_RATE + 1);
   localparam int unsigned REMAIN_W = TOTAL_W + OUT_W;
   localparam int unsigned ACC_W    = RATE_W + 1;
   localparam int unsigned RUN_W    = $clog2(MAX_RUN + 1);
   localparam int unsigned HCNT_W   = 4;

   localparam logic [ACC_W-1:0]   OUT_RATE_ACC = ACC_W'(OUT_RATE);
   localparam logic [OUT_W-1:0]   OUT_RATE_MUL = OUT_W'(OUT_RATE);
   localparam logic [31:0]        OUT_RATE_32  = 32'(OUT_RATE);
   localparam logic [RUN_W-1:0]   MAX_RUN_K    = RUN_W'(MAX_RUN);
   localparam logic [15:0]        VERSION_OK   = 16'(LUMP_VERSION);
   localparam logic [HCNT_W-1:0]  HDR_LAST     = HCNT_W'(HEADER_BYTES - 1);
   localparam logic [HCNT_W-1:0]  HDR_VER_HI   = HCNT_W'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_RUN,
      ST_REJ
   } st_type;

   typedef struct packed {
      logic in_header;
      logic complete;
      logic reject;
   } hdr_stat_type;

endpackage

>>> sv/slnr_header.sv
// header parser: collects version, source rate and sample count, flags bad headers
// depends on slnr_pkg
module slnr_header (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        beat,
   input  logic                        start,
   input  logic                        fin_eff,
   input  logic [7:0]                  lump_byte,
   output logic [slnr_pkg::RATE_W-1:0] source_rate,
   output logic [slnr_pkg::TOTAL_W-1:0] sample_total,
   output slnr_pkg::hdr_stat_type      hdr_stat
);
   import slnr_pkg::*;

   logic [HCNT_W-1:0]  header_count_ff, header_count_in, cnt_eff;
   logic [15:0]        version_word_ff, version_word_in, ver_eff;
   logic [RATE_W-1:0]  source_rate_ff, source_rate_in, rate_eff;
   logic [TOTAL_W-1:0] sample_total_ff, sample_total_in, total_eff;
   logic               take;
   logic               bad_version;
   logic               bad_tail;
   logic [31:0]        run_span;
   logic [TOTAL_W-1:0] total_new;

   always_comb begin
      cnt_eff   = start ? '0 : header_count_ff;
      ver_eff   = start ? '0 : version_word_ff;
      rate_eff  = start ? '0 : source_rate_ff;
      total_eff = start ? '0 : sample_total_ff;
   end

   assign take = beat && !fin_eff && (cnt_eff < HCNT_W'(HEADER_BYTES));

   always_comb begin
      header_count_in = cnt_eff;
      version_word_in = ver_eff;
      source_rate_in  = rate_eff;
      sample_total_in = total_eff;
      if (take) begin
         header_count_in = cnt_eff + HCNT_W'(1);
         case (cnt_eff)
            4'd0:    version_word_in[7:0]   = lump_byte;
            4'd1:    version_word_in[15:8]  = lump_byte;
            4'd2:    source_rate_in[7:0]    = lump_byte;
            4'd3:    source_rate_in[15:8]   = lump_byte;
            4'd4:    sample_total_in[7:0]   = lump_byte;
            4'd5:    sample_total_in[15:8]  = lump_byte;
            4'd6:    sample_total_in[23:16] = lump_byte;
            default: sample_total_in[31:24] = lump_byte;
         endcase
      end
   end

   // checks on the byte that completes the version field and on the last header byte
   always_comb begin
      total_new   = {lump_byte, total_eff[23:0]};
      run_span    = 32'(MAX_RUN) * {16'b0, rate_eff};
      bad_version = ({lump_byte, ver_eff[7:0]} != VERSION_OK);
      bad_tail    = (rate_eff == '0) || (total_new == '0) || (OUT_RATE_32 > run_span);
   end

   always_comb begin
      hdr_stat.in_header = cnt_eff < HCNT_W'(HEADER_BYTES);
      hdr_stat.complete  = take && (cnt_eff == HDR_LAST);
      hdr_stat.reject    = take && (((cnt_eff == HDR_VER_HI) && bad_version) ||
                                    ((cnt_eff == HDR_LAST) && bad_tail));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_count_ff <= '0;
         version_word_ff <= '0;
         source_rate_ff  <= '0;
         sample_total_ff <= '0;
      end else if (beat) begin
         header_count_ff <= header_count_in;
         version_word_ff <= version_word_in;
         source_rate_ff  <= source_rate_in;
         sample_total_ff <= sample_total_in;
      end
   end

   assign source_rate  = source_rate_ff;
   assign sample_total = sample_total_ff;

endmodule

>>> sv/sound_lump_nearest_resampler.sv
// top level of the sound lump nearest resampler: sequencer, phase accumulator, output register
// depends on slnr_pkg and slnr_header
//
// usage
//    req_ channel carries one lump byte per beat; req_lump_start marks byte 0 of a lump
//    rsp_ channel carries resampled samples with run_last, sound_done and rejected flags
//    header bytes are taken without stalling and give no beat; a bad version (byte 1) or
//    a bad rate, count or ratio (byte 7) gives one rejection beat
//    a sample byte is accepted, then the 32 x 15 multiply forms the remaining output count,
//    then the shared phase adder gives one output sample of its run per cycle unless
//    rsp_stall holds a valid result; a run is 0 to 64 samples, one or two for 11025 to 22050
//    req_stall is high from the cycle after a sample byte or rejecting header byte is taken
//    until its run or rejection beat is finished; results sit in a single output register;
//    while rsp_stall holds a valid result, the run pauses and the payload stays put
//    synchronous reset clears the parser and sequencer; bytes before any lump_start
//    are parsed as the start of a lump, and after the sound ends or is rejected bytes
//    are dropped until the next lump_start
module sound_lump_nearest_resampler (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_lump_byte,
   input  logic       req_lump_start,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_sample,
   output logic       rsp_run_last,
   output logic       rsp_sound_done,
   output logic       rsp_rejected
);
   import slnr_pkg::*;

   st_type              state_ff, state_in;
   logic                finished_ff, finished_in;
   logic [TOTAL_W-1:0]  source_index_ff, source_index_in;
   logic [RATE_W-1:0]   phase_ff, phase_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [RUN_W-1:0]    k_ff, k_in;
   logic [REMAIN_W-1:0] remain_ff, remain_in;
   logic [7:0]          sample_ff, sample_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_sample_ff, rsp_sample_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_done_ff, rsp_done_in;
   logic                rsp_rej_ff, rsp_rej_in;

   logic                beat;
   logic                fin_eff;
   logic                slot_free;
   logic [RATE_W-1:0]   source_rate;
   logic [TOTAL_W-1:0]  sample_total;
   hdr_stat_type        hdr_stat;

   logic [ACC_W-1:0]    acc_next;
   logic                run_done;
   logic                run_last;
   logic [ACC_W-1:0]    fin_acc;
   logic [RATE_W-1:0]   fin_phase;
   logic [TOTAL_W-1:0]  fin_index;
   logic                fin_end;

   assign req_stall = (state_ff != ST_IDLE);
   assign beat      = req_valid && !req_stall;
   assign fin_eff   = req_lump_start ? 1'b0 : finished_ff;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   slnr_header u_header (
      .clock        (clock),
      .reset        (reset),
      .beat         (beat),
      .start        (req_lump_start),
      .fin_eff      (fin_eff),
      .lump_byte    (req_lump_byte),
      .source_rate  (source_rate),
      .sample_total (sample_total),
      .hdr_stat     (hdr_stat)
   );

   // shared phase adder and run end checks
   always_comb begin
      acc_next = acc_ff + {1'b0, source_rate};
      run_done = {{(REMAIN_W-ACC_W){1'b0}}, acc_next} >= remain_ff;
      run_last = run_done || (acc_next >= OUT_RATE_ACC) ||
                 ((k_ff + RUN_W'(1)) >= MAX_RUN_K);
   end

   // end of a source sample: residual phase and index advance
   always_comb begin
      fin_acc   = (state_ff == ST_RUN) ? acc_next : {1'b0, phase_ff};
      fin_phase = (fin_acc >= OUT_RATE_ACC) ? RATE_W'(fin_acc - OUT_RATE_ACC) : '0;
      fin_index = source_index_ff + TOTAL_W'(1);
      fin_end   = fin_index >= sample_total;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (beat && !fin_eff) begin
               if (hdr_stat.reject) begin
                  state_in = ST_REJ;
               end else if (!hdr_stat.in_header) begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            state_in = ({1'b0, phase_ff} < OUT_RATE_ACC) ? ST_RUN : ST_IDLE;
         end
         ST_RUN: begin
            if (slot_free && run_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_REJ: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      finished_in     = finished_ff;
      source_index_in = source_index_ff;
      phase_in        = phase_ff;
      acc_in          = acc_ff;
      k_in            = k_ff;
      remain_in       = remain_ff;
      sample_in       = sample_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_sample_in   = rsp_sample_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_done_in     = rsp_done_ff;
      rsp_rej_in      = rsp_rej_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (beat) begin
               if (req_lump_start) begin
                  finished_in     = 1'b0;
                  source_index_in = '0;
                  phase_in        = '0;
               end
               if (!fin_eff) begin
                  if (hdr_stat.reject) begin
                     finished_in = 1'b1;
                  end else if (hdr_stat.complete) begin
                     source_index_in = '0;
                     phase_in        = '0;
                  end else if (!hdr_stat.in_header) begin
                     sample_in = req_lump_byte;
                  end
               end
            end
         end
         ST_MUL: begin
            remain_in = REMAIN_W'(sample_total - source_index_ff) *
                        {{(REMAIN_W-OUT_W){1'b0}}, OUT_RATE_MUL};
            acc_in    = {1'b0, phase_ff};
            k_in      = '0;
            if ({1'b0, phase_ff} >= OUT_RATE_ACC) begin
               phase_in        = fin_phase;
               source_index_in = fin_index;
               finished_in     = fin_end;
            end
         end
         ST_RUN: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = sample_ff;
               rsp_last_in   = run_last;
               rsp_done_in   = run_done;
               rsp_rej_in    = 1'b0;
               acc_in        = acc_next;
               k_in          = k_ff + RUN_W'(1);
               if (run_done) begin
                  finished_in = 1'b1;
               end else if (run_last) begin
                  phase_in        = fin_phase;
                  source_index_in = fin_index;
                  finished_in     = fin_end;
               end
            end
         end
         ST_REJ: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = '0;
               rsp_last_in   = 1'b1;
               rsp_done_in   = 1'b0;
               rsp_rej_in    = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         finished_ff     <= 1'b0;
         source_index_ff <= '0;
         phase_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         finished_ff     <= finished_in;
         source_index_ff <= source_index_in;
         phase_ff        <= phase_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff        <= acc_in;
      k_ff          <= k_in;
      remain_ff     <= remain_in;
      sample_ff     <= sample_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_rej_ff    <= rsp_rej_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_sample = rsp_sample_ff;
   assign rsp_run_last   = rsp_last_ff;
   assign rsp_sound_done = rsp_done_ff;
   assign rsp_rejected   = rsp_rej_ff;

endmodule

>>> bench/tb.sv
// self-checking bench for sound_lump_nearest_resampler: a lump parser and resampler tracker
// predicts every rsp_ beat; depends on slnr_pkg and the block under test
`timescale 1ns / 1ps

module tb;
   import slnr_pkg::*;

   localparam int unsigned IDLE_LIMIT  = 4000;
   localparam int unsigned TARGET_BEATS = 420;
   localparam int unsigned VER_BYTES   = 2;
   localparam int unsigned RATE_END    = 4;
   localparam int unsigned MAX_REPORTS = 10;

   typedef struct packed {
      logic [7:0] smp;
      logic       last;
      logic       done;
      logic       rej;
   } sample_beat_type;

   class resample_tracker;
      int unsigned      hdr_taken;
      logic [15:0]      ver;
      logic [15:0]      rate;
      logic [31:0]      total;
      logic [31:0]      idx;
      logic [19:0]      phase;
      bit               ended;
      sample_beat_type  expected_samples[$];
      int unsigned      errors;
      int unsigned      live_beats;

      function void clear();
         hdr_taken = 0;
         ver = '0;
         rate = '0;
         total = '0;
         idx = '0;
         phase = '0;
         ended = 1'b0;
      endfunction

      function void reject_lump();
         sample_beat_type r;
         r = '{smp: 8'h00, last: 1'b1, done: 1'b0, rej: 1'b1};
         ended = 1'b1;
         expected_samples.push_back(r);
      endfunction

      function void note_byte(logic [7:0] b, logic s);
         longint unsigned f, p, remain, np;
         int k;
         bit hit;
         sample_beat_type r;
         sample_beat_type run_q[$];
         live_beats++;
         if (s) clear();
         if (ended) return;
         if (hdr_taken < HEADER_BYTES) begin
            if (hdr_taken < VER_BYTES) ver[8*hdr_taken +: 8] = b;
            else if (hdr_taken < RATE_END) rate[8*(hdr_taken-VER_BYTES) +: 8] = b;
            else total[8*(hdr_taken-RATE_END) +: 8] = b;
            hdr_taken++;
            if (hdr_taken == VER_BYTES && ver != VERSION_OK) begin
               reject_lump();
               return;
            end
            if (hdr_taken == HEADER_BYTES) begin
               if (rate == 0 || total == 0 ||
                   longint'(OUT_RATE) > longint'(MAX_RUN) * longint'(rate)) begin
                  reject_lump();
                  return;
               end
               phase = '0;
               idx = '0;
            end
            return;
         end
         f = rate;
         p = phase;
         remain = longint'(total - idx) * longint'(OUT_RATE);
         k = 0;
         while (k < MAX_RUN && p + k * f < OUT_RATE) begin
            hit = (p + (k + 1) * f >= remain);
            r = '{smp: b, last: 1'b0, done: hit, rej: 1'b0};
            run_q.push_back(r);
            k++;
            if (hit) begin
               ended = 1'b1;
               break;
            end
         end
         if (k > 0) run_q[k-1].last = 1'b1;
         foreach (run_q[i]) expected_samples.push_back(run_q[i]);
         if (!ended) begin
            np = p + k * f;
            np = (np >= OUT_RATE) ? np - OUT_RATE : 0;
            phase = np[19:0];
            idx = idx + 1;
            if (idx >= total) ended = 1'b1;
         end
      endfunction

      function void check_sample(sample_beat_type got);
         sample_beat_type want;
         if (expected_samples.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("unexpected rsp beat: sample %0d last %0d done %0d rej %0d",
                        got.smp, got.last, got.done, got.rej);
            return;
         end
         want = expected_samples.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("rsp mismatch: exp sample %0d last %0d done %0d rej %0d,",
                        want.smp, want.last, want.done, want.rej,
                        " got sample %0d last %0d done %0d rej %0d",
                        got.smp, got.last, got.done, got.rej);
         end
      endfunction

      function int pending();
         return expected_samples.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_lump_byte = 8'h00;
   logic       req_lump_start = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_sample;
   logic       rsp_run_last;
   logic       rsp_sound_done;
   logic       rsp_rejected;

   resample_tracker trk;
   int unsigned     idle_cycles = 0;
   int unsigned     cyc_count = 0;
   int              burst_left = 1;
   int              stall_mode = 0;
   int              stall_hold = 0;

   sound_lump_nearest_resampler u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_lump_byte  (req_lump_byte),
      .req_lump_start (req_lump_start),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_sample (rsp_out_sample),
      .rsp_run_last   (rsp_run_last),
      .rsp_sound_done (rsp_sound_done),
      .rsp_rejected   (rsp_rejected)
   );

   always #1 clock = ~clock;

   // result sampling, receiver stall pattern and idle counting
   always @(posedge clock) begin
      cyc_count++;
      if (!reset && rsp_valid && !rsp_stall)
         trk.check_sample('{smp: rsp_out_sample, last: rsp_run_last,
                            done: rsp_sound_done, rej: rsp_rejected});
      if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (cyc_count % 256 == 0) stall_mode = $urandom_range(0, 3);
      if (stall_hold != 0) begin
         stall_hold--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: begin
               if ($urandom_range(0, 2) == 0) begin
                  stall_hold = $urandom_range(0, 7);
                  rsp_stall <= 1'b1;
               end else begin
                  rsp_stall <= 1'b0;
               end
            end
            default: rsp_stall <= (cyc_count % 8 < 3);
         endcase
      end
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("Regression FAIL");
      $finish;
   end

   function automatic int pick_burst();
      if ($urandom_range(0, 4) == 0) return $urandom_range(40, 120);
      return $urandom_range(1, 10);
   endfunction

   task automatic send_beat(input logic [7:0] b, input logic s);
      req_valid <= 1'b1;
      req_lump_byte <= b;
      req_lump_start <= s;
      do @(posedge clock); while (req_stall);
      trk.note_byte(b, s);
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = pick_burst();
      end
   endtask

   task automatic send_header(input logic [15:0] ver, input logic [15:0] rate,
                              input logic [31:0] total);
      send_beat(ver[7:0], 1'b1);
      send_beat(ver[15:8], 1'b0);
      send_beat(rate[7:0], 1'b0);
      send_beat(rate[15:8], 1'b0);
      for (int i = 0; i < 4; i++) send_beat(total[8*i +: 8], 1'b0);
   endtask

   task automatic send_samples(input int n);
      for (int i = 0; i < n; i++) send_beat(8'($urandom_range(0, 255)), 1'b0);
   endtask

   task automatic random_lump();
      logic [15:0] ver, rate;
      logic [31:0] total;
      int          kind, n;
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
         case ($urandom_range(0, 7))
            0: rate = 16'd11025;
            1: rate = 16'd22050;
            2: rate = 16'd44100;
            3: rate = 16'd8000;
            4: rate = 16'd345;
            5: rate = 16'hFFFF;
            6: rate = 16'd48000;
            default: rate = 16'($urandom_range(345, 65535));
         endcase
         if ($urandom_range(0, 9) == 0) begin
            total = $urandom();
            n = $urandom_range(1, 6);
         end else begin
            total = $urandom_range(1, 10);
            if ($urandom_range(0, 4) == 0) n = $urandom_range(0, total - 1);
            else n = total + $urandom_range(0, 2);
         end
         send_header(VERSION_OK, rate, total);
         send_samples(n);
      end else if (kind < 80) begin
         ver = 16'($urandom());
         if (ver == VERSION_OK) ver[15] = 1'b1;
         send_beat(ver[7:0], 1'b1);
         send_beat(ver[15:8], 1'b0);
         send_samples($urandom_range(0, 2));
      end else if (kind < 85) begin
         send_header(VERSION_OK, 16'd0, $urandom());
         send_samples($urandom_range(0, 2));
      end else if (kind < 90) begin
         send_header(VERSION_OK, 16'($urandom()), 32'd0);
         send_samples($urandom_range(0, 2));
      end else if (kind < 95) begin
         send_header(VERSION_OK, 16'($urandom_range(1, 344)), $urandom());
         send_samples($urandom_range(0, 2));
      end else begin
         n = $urandom_range(3, 10);
         for (int i = 0; i < n; i++)
            send_beat(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
      end
   endtask

   initial begin
      trk = new();
      trk.clear();
      trk.errors = 0;
      trk.live_beats = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      burst_left = pick_burst();

      // bad version with no lump_start, then a dropped byte
      send_beat(8'hFF, 1'b0);
      send_beat(8'h00, 1'b0);
      send_beat(8'h5A, 1'b0);
      // lowest accepted rate, full 64-sample runs, extremes, byte past the count
      send_header(VERSION_OK, 16'd345, 32'd2);
      send_beat(8'h00, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_beat(8'hA5, 1'b0);
      // version high byte set
      send_beat(8'h03, 1'b1);
      send_beat(8'h01, 1'b0);
      // zero rate
      send_header(VERSION_OK, 16'd0, 32'd5);

      while (trk.live_beats < TARGET_BEATS) random_lump();

      req_valid <= 1'b0;
      while (trk.pending() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (trk.errors == 0 && trk.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         if (trk.pending() != 0)
            $display("%0d expected beats never arrived", trk.pending());
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/slnr_pkg.sv
sv/slnr_header.sv
sv/sound_lump_nearest_resampler.sv
bench/tb.sv
